FILE: sv/qtsc_pkg.sv
// ----------------------------------------------------------------------------
// qtsc_pkg: shared types and constants for the tensor storage calculator
// Status codes, the quantization type table and datapath widths.
// ----------------------------------------------------------------------------
package qtsc_pkg;

	localparam int DIM_W      = 64;
	localparam int HALF_W     = DIM_W / 2;
	localparam int BYTES_W    = 9;
	localparam int LOG2_W     = 4;
	localparam int RANK_W     = 3;
	localparam int QTYPE_W    = 8;
	localparam int MAX_DIMS   = 4;
	localparam int S_TDATA_W  = 336;
	localparam int M_TDATA_W  = 264;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_UNKNOWN   = 4'd1,
		ST_REMOVED   = 4'd2,
		ST_RESERVED  = 4'd3,
		ST_OUTSIDE   = 4'd4,
		ST_NOGEOM    = 4'd5,
		ST_RANK      = 4'd6,
		ST_ZERODIM   = 4'd7,
		ST_BLOCK     = 4'd8,
		ST_ELEM_OVF  = 4'd9,
		ST_ROWB_OVF  = 4'd10,
		ST_ROWC_OVF  = 4'd11,
		ST_TOTAL_OVF = 4'd12,
		ST_MISMATCH  = 4'd13
	} qtsc_status_t;

	// Block widths are all powers of two, so the table keeps log2.
	typedef struct packed {
		qtsc_status_t         admit;
		logic [LOG2_W-1:0]    blk_log2;
		logic [BYTES_W-1:0]   bytes;
	} type_entry_t;

	function automatic type_entry_t mk(input qtsc_status_t admit,
			input logic [LOG2_W-1:0] blk_log2, input logic [BYTES_W-1:0] bytes);
		type_entry_t e;
		e.admit    = admit;
		e.blk_log2 = blk_log2;
		e.bytes    = bytes;
		return e;
	endfunction

	function automatic type_entry_t type_lookup(input logic [QTYPE_W-1:0] qtype);
		type_entry_t e;
		case (qtype)
			8'd0:  e = mk(ST_OK, 4'd0, 9'd4);
			8'd1:  e = mk(ST_OK, 4'd0, 9'd2);
			8'd2:  e = mk(ST_OK, 4'd5, 9'd18);
			8'd3:  e = mk(ST_OK, 4'd5, 9'd20);
			8'd4:  e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd5:  e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd6:  e = mk(ST_OK, 4'd5, 9'd22);
			8'd7:  e = mk(ST_OK, 4'd5, 9'd24);
			8'd8:  e = mk(ST_OK, 4'd5, 9'd34);
			8'd9:  e = mk(ST_OK, 4'd5, 9'd36);
			8'd10: e = mk(ST_OK, 4'd8, 9'd84);
			8'd11: e = mk(ST_OK, 4'd8, 9'd110);
			8'd12: e = mk(ST_OK, 4'd8, 9'd144);
			8'd13: e = mk(ST_OK, 4'd8, 9'd176);
			8'd14: e = mk(ST_OK, 4'd8, 9'd210);
			8'd15: e = mk(ST_OK, 4'd8, 9'd292);
			8'd16: e = mk(ST_OK, 4'd8, 9'd66);
			8'd17: e = mk(ST_OK, 4'd8, 9'd74);
			8'd18: e = mk(ST_OK, 4'd8, 9'd98);
			8'd19: e = mk(ST_OK, 4'd8, 9'd50);
			8'd20: e = mk(ST_OK, 4'd5, 9'd18);
			8'd21: e = mk(ST_OK, 4'd8, 9'd110);
			8'd22: e = mk(ST_OK, 4'd8, 9'd82);
			8'd23: e = mk(ST_OK, 4'd8, 9'd136);
			8'd24: e = mk(ST_OK, 4'd0, 9'd1);
			8'd25: e = mk(ST_OK, 4'd0, 9'd2);
			8'd26: e = mk(ST_OK, 4'd0, 9'd4);
			8'd27: e = mk(ST_OK, 4'd0, 9'd8);
			8'd28: e = mk(ST_OK, 4'd0, 9'd8);
			8'd29: e = mk(ST_OK, 4'd8, 9'd56);
			8'd30: e = mk(ST_OK, 4'd0, 9'd2);
			8'd31: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd32: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd33: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd34: e = mk(ST_OK, 4'd8, 9'd54);
			8'd35: e = mk(ST_OK, 4'd8, 9'd66);
			8'd36: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd37: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd38: e = mk(ST_REMOVED, 4'd0, 9'd0);
			8'd39: e = mk(ST_OK, 4'd5, 9'd17);
			8'd40: e = mk(ST_OUTSIDE, 4'd6, 9'd36);
			8'd41: e = mk(ST_OUTSIDE, 4'd7, 9'd18);
			8'd42: e = mk(ST_OUTSIDE, 4'd6, 9'd18);
			default: e = mk(ST_UNKNOWN, 4'd0, 9'd0);
		endcase
		return e;
	endfunction

endpackage

FILE: sv/qtsc_mul64.sv
// ----------------------------------------------------------------------------
// qtsc_mul64: two-stage 64x64 multiply with overflow flag
// Stage A forms two 32x32 partial products, stage B adds them and flags
// any product that does not fit in 64 bits.
// ----------------------------------------------------------------------------
module qtsc_mul64
	import qtsc_pkg::*;
(
	input  logic              clk,
	input  logic              en_a,
	input  logic              en_b,
	input  logic [DIM_W-1:0]  a,
	input  logic [DIM_W-1:0]  b,
	output logic [DIM_W-1:0]  p,
	output logic              ovf
);

	logic [HALF_W-1:0] a_hi, a_lo, b_hi, b_lo, x_op, y_op;
	logic              a_hi_nz;
	logic [DIM_W-1:0]  ll_s1, cross_s1;
	logic              both_s1;
	logic [DIM_W:0]    sum;
	logic [DIM_W-1:0]  p_s2;
	logic              ovf_s2;

	assign a_hi = a[DIM_W-1:HALF_W];
	assign a_lo = a[HALF_W-1:0];
	assign b_hi = b[DIM_W-1:HALF_W];
	assign b_lo = b[HALF_W-1:0];
	assign a_hi_nz = |a_hi;

	// only one cross term can be nonzero unless both high halves are
	assign x_op = a_hi_nz ? a_hi : a_lo;
	assign y_op = a_hi_nz ? b_lo : b_hi;

	always_ff @(posedge clk) begin
		if (en_a) begin
			ll_s1    <= DIM_W'(a_lo) * DIM_W'(b_lo);
			cross_s1 <= DIM_W'(x_op) * DIM_W'(y_op);
			both_s1  <= a_hi_nz & (|b_hi);
		end
	end

	assign sum = {1'b0, ll_s1} + {1'b0, cross_s1[HALF_W-1:0], {HALF_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (en_b) begin
			p_s2   <= sum[DIM_W-1:0];
			ovf_s2 <= both_s1 | (|cross_s1[DIM_W-1:HALF_W]) | sum[DIM_W];
		end
	end

	assign p   = p_s2;
	assign ovf = ovf_s2;

endmodule

FILE: sv/quantized_tensor_storage_calc.sv
// ----------------------------------------------------------------------------
// quantized_tensor_storage_calc: storage size of a quantized tensor
// Checks a tensor descriptor against the type table and computes row size,
// row count, element count and tensor size with 64-bit overflow checks.
// ----------------------------------------------------------------------------
//
// channel  dir  beat contents
// -------  ---  ------------------------------------------------------------
// s_*      in   tuser: cmd; tdata: qtype, rank, dim0..dim3, stored_len
// m_*      out  tdata: status, row_size, nrows, elem_count,
//                      tensor_size
//
// Eight register stages between input beat and output beat;
// one beat in and one beat out per cycle sustained while the output does not stall.
// The depth is set by the row count chain: dim1*dim2, then *dim3, then
// *dim0 and *row_size, each a 64x64 product split over two stages.
// Each stage takes a beat when empty or when the next stage moves, so
// bubbles close up while the output stalls. Reset clears only valid bits.
// ----------------------------------------------------------------------------
module quantized_tensor_storage_calc
	import qtsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] qtype, [10:8] rank, [74:11] dim0, [138:75] dim1,
	// [202:139] dim2, [266:203] dim3, [330:267] stored_len, rest zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [0] cmd
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [3:0] status, [67:4] row_size, [131:68] nrows,
	// [195:132] elem_count, [259:196] tensor_size, rest zero
	output logic [M_TDATA_W-1:0]  m_tdata
);

	localparam int NSTAGE = 8;
	localparam int RB_W   = DIM_W + BYTES_W;

	// ---------------- stage control ----------------
	logic [NSTAGE:1] vld_q, vin, rdy, ld;

	always_comb begin
		vin = {vld_q[NSTAGE-1:1], s_tvalid};
		rdy[NSTAGE] = ~vld_q[NSTAGE] | m_tready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			rdy[k] = ~vld_q[k] | rdy[k+1];
		end
		ld = vin & rdy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NSTAGE];

	// ---------------- input unpack ----------------
	logic [QTYPE_W-1:0] qtype_in;
	logic [RANK_W-1:0]  rank_in;
	logic [DIM_W-1:0]   dim_in [MAX_DIMS];
	logic [DIM_W-1:0]   actual_in;
	logic               cmd_in;

	assign qtype_in  = s_tdata[7:0];
	assign rank_in   = s_tdata[10:8];
	assign dim_in[0] = s_tdata[74:11];
	assign dim_in[1] = s_tdata[138:75];
	assign dim_in[2] = s_tdata[202:139];
	assign dim_in[3] = s_tdata[266:203];
	assign actual_in = s_tdata[330:267];
	assign cmd_in    = s_tuser[0];

	// ---------------- stage 1: table, front checks ----------------
	// Early refusals are resolved here in check order; later overflow
	// flags only matter if this status is still ok.
	type_entry_t   te;
	logic          rank_ok, zero_dim, blk_mis;
	logic [DIM_W-1:0] blk_mask;
	logic [DIM_W-1:0] dim_eff [MAX_DIMS];
	qtsc_status_t  pre_nx;

	always_comb begin
		te       = type_lookup(qtype_in);
		rank_ok  = (rank_in != '0) && (rank_in <= RANK_W'(MAX_DIMS));
		zero_dim = 1'b0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			if ((RANK_W'(i) < rank_in) && (dim_in[i] == '0)) begin
				zero_dim = 1'b1;
			end
			// unused dimensions act as 1 in the row count
			dim_eff[i] = (RANK_W'(i) < rank_in) ? dim_in[i] : DIM_W'(1);
		end
		blk_mask = (DIM_W'(1) << te.blk_log2) - DIM_W'(1);
		blk_mis  = |(dim_in[0] & blk_mask);
		if (te.admit != ST_OK) begin
			pre_nx = te.admit;
		end else if (te.bytes == '0) begin
			pre_nx = ST_NOGEOM;
		end else if (!rank_ok) begin
			pre_nx = ST_RANK;
		end else if (zero_dim) begin
			pre_nx = ST_ZERODIM;
		end else if (blk_mis) begin
			pre_nx = ST_BLOCK;
		end else begin
			pre_nx = ST_OK;
		end
	end

	qtsc_status_t       pre_s1;
	logic               cmd_s1;
	logic [DIM_W-1:0]   actual_s1, d0_s1, d1_s1, d2_s1, d3_s1, blocks_s1;
	logic [BYTES_W-1:0] bytes_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pre_s1    <= pre_nx;
			cmd_s1    <= cmd_in;
			actual_s1 <= actual_in;
			d0_s1     <= dim_in[0];
			d1_s1     <= dim_eff[1];
			d2_s1     <= dim_eff[2];
			d3_s1     <= dim_eff[3];
			blocks_s1 <= dim_in[0] >> te.blk_log2;
			bytes_s1  <= te.bytes;
		end
	end

	// ---------------- stage 2: row size, dim1*dim2 partials ----------------
	logic [RB_W-1:0]  rb_full;
	qtsc_status_t     pre_s2;
	logic             cmd_s2, rbovf_s2;
	logic [DIM_W-1:0] actual_s2, d0_s2, d3_s2, rb_s2;

	assign rb_full = RB_W'(blocks_s1) * RB_W'(bytes_s1);

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pre_s2    <= pre_s1;
			cmd_s2    <= cmd_s1;
			actual_s2 <= actual_s1;
			d0_s2     <= d0_s1;
			d3_s2     <= d3_s1;
			rb_s2     <= rb_full[DIM_W-1:0];
			rbovf_s2  <= |rb_full[RB_W-1:DIM_W];
		end
	end

	logic [DIM_W-1:0] p12;
	logic             ovf12;

	qtsc_mul64 u_mul_12 (
		.clk  (clk),
		.en_a (ld[2]),
		.en_b (ld[3]),
		.a    (d1_s1),
		.b    (d2_s1),
		.p    (p12),
		.ovf  (ovf12)
	);

	// ---------------- stage 3 ----------------
	qtsc_status_t     pre_s3;
	logic             cmd_s3, rbovf_s3;
	logic [DIM_W-1:0] actual_s3, d0_s3, d3_s3, rb_s3;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			pre_s3    <= pre_s2;
			cmd_s3    <= cmd_s2;
			actual_s3 <= actual_s2;
			d0_s3     <= d0_s2;
			d3_s3     <= d3_s2;
			rb_s3     <= rb_s2;
			rbovf_s3  <= rbovf_s2;
		end
	end

	// ---------------- stages 4-5: row count = p12 * dim3 ----------------
	logic [DIM_W-1:0] rc;
	logic             ovf_rc3;

	qtsc_mul64 u_mul_rc (
		.clk  (clk),
		.en_a (ld[4]),
		.en_b (ld[5]),
		.a    (p12),
		.b    (d3_s3),
		.p    (rc),
		.ovf  (ovf_rc3)
	);

	qtsc_status_t     pre_s4, pre_s5;
	logic             cmd_s4, cmd_s5, rbovf_s4, rbovf_s5, ovf12_s4, ovf12_s5;
	logic [DIM_W-1:0] actual_s4, actual_s5, d0_s4, d0_s5, rb_s4, rb_s5;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			pre_s4    <= pre_s3;
			cmd_s4    <= cmd_s3;
			actual_s4 <= actual_s3;
			d0_s4     <= d0_s3;
			rb_s4     <= rb_s3;
			rbovf_s4  <= rbovf_s3;
			ovf12_s4  <= ovf12;
		end
		if (ld[5]) begin
			pre_s5    <= pre_s4;
			cmd_s5    <= cmd_s4;
			actual_s5 <= actual_s4;
			d0_s5     <= d0_s4;
			rb_s5     <= rb_s4;
			rbovf_s5  <= rbovf_s4;
			ovf12_s5  <= ovf12_s4;
		end
	end

	// ---------------- stages 6-7: element count and tensor size ----------------
	// With every dimension nonzero the partial products only grow, so any
	// overflow in the chain means the full product overflows.
	logic [DIM_W-1:0] ec, tb;
	logic             ec_ovf, tb_ovf;

	qtsc_mul64 u_mul_ec (
		.clk  (clk),
		.en_a (ld[6]),
		.en_b (ld[7]),
		.a    (d0_s5),
		.b    (rc),
		.p    (ec),
		.ovf  (ec_ovf)
	);

	qtsc_mul64 u_mul_tb (
		.clk  (clk),
		.en_a (ld[6]),
		.en_b (ld[7]),
		.a    (rb_s5),
		.b    (rc),
		.p    (tb),
		.ovf  (tb_ovf)
	);

	qtsc_status_t     pre_s6, pre_s7;
	logic             cmd_s6, cmd_s7, rbovf_s6, rbovf_s7, rcovf_s6, rcovf_s7;
	logic [DIM_W-1:0] actual_s6, actual_s7, rb_s6, rb_s7, rc_s6, rc_s7;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			pre_s6    <= pre_s5;
			cmd_s6    <= cmd_s5;
			actual_s6 <= actual_s5;
			rb_s6     <= rb_s5;
			rbovf_s6  <= rbovf_s5;
			rcovf_s6  <= ovf12_s5 | ovf_rc3;
			rc_s6     <= rc;
		end
		if (ld[7]) begin
			pre_s7    <= pre_s6;
			cmd_s7    <= cmd_s6;
			actual_s7 <= actual_s6;
			rb_s7     <= rb_s6;
			rbovf_s7  <= rbovf_s6;
			rcovf_s7  <= rcovf_s6;
			rc_s7     <= rc_s6;
		end
	end

	// ---------------- stage 8: final status, output register ----------------
	qtsc_status_t     st_nx;
	logic             keep;

	always_comb begin
		if (pre_s7 != ST_OK) begin
			st_nx = pre_s7;
		end else if (rbovf_s7) begin
			st_nx = ST_ROWB_OVF;
		end else if (rcovf_s7) begin
			st_nx = ST_ROWC_OVF;
		end else if (ec_ovf) begin
			st_nx = ST_ELEM_OVF;
		end else if (tb_ovf) begin
			st_nx = ST_TOTAL_OVF;
		end else if (cmd_s7 && (tb != actual_s7)) begin
			st_nx = ST_MISMATCH;
		end else begin
			st_nx = ST_OK;
		end
		// counts go out only with ok or mismatch
		keep = (st_nx == ST_OK) || (st_nx == ST_MISMATCH);
	end

	qtsc_status_t     status_s8;
	logic [DIM_W-1:0] rb_s8, rc_s8, ec_s8, tb_s8;

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			status_s8 <= st_nx;
			rb_s8     <= keep ? rb_s7 : '0;
			rc_s8     <= keep ? rc_s7 : '0;
			ec_s8     <= keep ? ec : '0;
			tb_s8     <= keep ? tb : '0;
		end
	end

	assign m_tdata = {4'b0, tb_s8, ec_s8, rc_s8, rb_s8, status_s8};

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(status_s8 == ST_OK || status_s8 == ST_MISMATCH) |->
		rb_s8 == '0 && rc_s8 == '0 && ec_s8 == '0 && tb_s8 == '0)
		else $error("refused descriptor carries nonzero counts");

	a_counts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s8 == ST_OK || status_s8 == ST_MISMATCH) |->
		rb_s8 != '0 && rc_s8 != '0 && ec_s8 != '0 && tb_s8 != '0)
		else $error("accepted descriptor with a zero count");
`endif

endmodule
